[src/tffc_pkg.sv]
// Shared constants, payload types and helper functions of the thermal
// flat-field correction block. No dependencies.
`timescale 1ns / 1ps

package tffc_pkg;

  localparam int unsigned FRAME_PIXELS = 60 * 80;
  localparam int unsigned PIXEL_BITS   = 16;
  localparam int unsigned PIXEL_W      = 16;
  localparam int unsigned POS_W        = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  localparam logic [PIXEL_W-1:0] PIXEL_MASK = PIXEL_W'((17'd1 << PIXEL_BITS) - 17'd1);
  localparam logic [PIXEL_W-1:0] PIXEL_MAX  = '1;
  localparam logic [POS_W-1:0]   POS_LAST   = POS_W'(FRAME_PIXELS - 1);

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_value;
    logic               baseline_frame;
  } tffc_in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] corrected_pixel;
    logic               frame_end;
    logic [PIXEL_W-1:0] frame_min;
    logic [PIXEL_W-1:0] frame_max;
  } tffc_out_t;

  // a - b, floored at zero
  function automatic logic [PIXEL_W-1:0] sat_sub(input logic [PIXEL_W-1:0] a,
                                                 input logic [PIXEL_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

[src/tffc_if.sv]
// Valid/ready stream interfaces for pixel words in and corrected words out.
// Depends on tffc_pkg for the payload types.
`timescale 1ns / 1ps

interface tffc_in_if import tffc_pkg::*; ();
  logic     valid;
  logic     ready;
  tffc_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tffc_out_if import tffc_pkg::*; ();
  logic      valid;
  logic      ready;
  tffc_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[src/thermal_flat_field_correction_core.sv]
// Thermal flat-field correction core: streams raw pixels, stores baseline
// frames and subtracts them from the others. Depends on tffc_pkg, tffc_if.
`timescale 1ns / 1ps

// The core takes one pixel word per clock, frame after frame in raster order,
// and sustains one word per cycle in both directions unless the output stalls;
// a pixel's result passes stage 1, stage 2 and then the output register. The
// rate is set by the single baseline memory, which takes one write (baseline
// frames) or one read (corrected frames) per cycle. A frame whose first pixel
// carries baseline_frame is written raw into the memory and gives no words
// out; its minimum becomes the offset at its last pixel. Every other frame
// gives one corrected word per pixel: pixel minus (baseline - offset), both
// floored at zero, with the frame's minimum and maximum on the last word. After
// reset the baseline reads as zero until the first baseline frame begins; there
// is no clearing pass, so pixels are accepted straight out of reset. A word
// waiting in the output register does not block input unless it is stalled.

module thermal_flat_field_correction_core import tffc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tffc_in_if.sink   pix_i,
  tffc_out_if.source res_o
);

  // pipeline advance: the output register is free or being emptied
  logic adv;
  logic in_acc;

  // frame tracking
  logic [POS_W-1:0]   pos_q;
  logic               capturing_q;
  logic               capturing_d;
  logic               first_px;
  logic               last_px;
  logic [PIXEL_W-1:0] px;

  // baseline state
  logic [PIXEL_W-1:0] base_mem [FRAME_PIXELS];
  logic [PIXEL_W-1:0] rd_data_q;
  logic [PIXEL_W-1:0] offset_q;
  logic [PIXEL_W-1:0] cap_min_q;
  logic [PIXEL_W-1:0] cap_min_d;
  logic               base_valid_q;
  logic               wr_en;
  logic               rd_en;

  // stage 1: memory read in flight
  logic               s1_valid_q;
  logic               s1_first_q;
  logic               s1_last_q;
  logic [PIXEL_W-1:0] s1_px_q;
  logic [PIXEL_W-1:0] s1_base;
  logic [PIXEL_W-1:0] s1_corr;

  // stage 2: corrected pixel
  logic               s2_valid_q;
  logic               s2_first_q;
  logic               s2_last_q;
  logic [PIXEL_W-1:0] s2_corr_q;
  logic [PIXEL_W-1:0] run_min_q;
  logic [PIXEL_W-1:0] run_max_q;
  logic [PIXEL_W-1:0] run_min_d;
  logic [PIXEL_W-1:0] run_max_d;

  // output register
  logic      out_valid_q;
  tffc_out_t out_q;

  assign adv          = !out_valid_q || res_o.ready;
  assign pix_i.ready  = adv;
  assign in_acc       = pix_i.valid && adv;

  assign px          = pix_i.payload.pixel_value & PIXEL_MASK;
  assign first_px    = (pos_q == '0);
  assign last_px     = (pos_q == POS_LAST);
  // sample the baseline flag only at the first pixel of a frame
  assign capturing_d = first_px ? pix_i.payload.baseline_frame : capturing_q;
  assign wr_en       = in_acc && capturing_d;
  assign rd_en       = in_acc && !capturing_d;

  always_comb begin
    if (first_px) begin
      cap_min_d = px;
    end else begin
      cap_min_d = (px < cap_min_q) ? px : cap_min_q;
    end
  end

  // frame position, capture flag, offset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      capturing_q  <= 1'b0;
      cap_min_q    <= PIXEL_MAX;
      offset_q     <= '0;
      base_valid_q <= 1'b0;
    end else if (in_acc) begin
      pos_q       <= last_px ? '0 : pos_q + 1'b1;
      capturing_q <= capturing_d;
      if (capturing_d) begin
        cap_min_q    <= cap_min_d;
        base_valid_q <= 1'b1;
        if (last_px) begin
          offset_q <= cap_min_d;
        end
      end
    end
  end

  // baseline memory: one write or one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      base_mem[pos_q] <= px;
    end
    if (rd_en) begin
      rd_data_q <= base_mem[pos_q];
    end
  end

  // stage 1 control and pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_first_q <= first_px;
      s1_last_q  <= last_px;
      s1_px_q    <= px;
    end
  end

  // baseline is zero until the first capture has begun writing
  assign s1_base = base_valid_q ? sat_sub(rd_data_q, offset_q) : '0;
  assign s1_corr = sat_sub(s1_px_q, s1_base);

  // stage 2: hold the corrected pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_corr_q  <= s1_corr;
    end
  end

  // running extremes restart at each frame's first pixel
  always_comb begin
    if (s2_first_q) begin
      run_min_d = s2_corr_q;
      run_max_d = s2_corr_q;
    end else begin
      run_min_d = (s2_corr_q < run_min_q) ? s2_corr_q : run_min_q;
      run_max_d = (s2_corr_q > run_max_q) ? s2_corr_q : run_max_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_min_q   <= PIXEL_MAX;
      run_max_q   <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
      if (s2_valid_q) begin
        run_min_q <= run_min_d;
        run_max_q <= run_max_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      out_q.corrected_pixel <= s2_corr_q;
      out_q.frame_end       <= s2_last_q;
      out_q.frame_min       <= s2_last_q ? run_min_d : '0;
      out_q.frame_max       <= s2_last_q ? run_max_d : '0;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

endmodule

[tb/tffc_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the thermal flat-field correction core: predicts each corrected word
// from the accepted pixels and compares it with the output stream.
// Depends on tffc_pkg and the tffc_in_if / tffc_out_if stream interfaces.

module tffc_checker import tffc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tffc_in_if          pix_i,
  tffc_out_if         res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [PIXEL_W-1:0] baseline_mem [FRAME_PIXELS];
  logic [PIXEL_W-1:0] offset_q;
  logic [PIXEL_W-1:0] capture_min_q;
  logic [PIXEL_W-1:0] frame_min_q;
  logic [PIXEL_W-1:0] frame_max_q;
  logic [POS_W-1:0]   position_q;
  logic               capturing_q;
  tffc_out_t          corrected_q[$];
  int unsigned        fail_count = 0;

  function automatic logic [PIXEL_W-1:0] clamp_diff(input logic [PIXEL_W-1:0] a,
                                                    input logic [PIXEL_W-1:0] b);
    if (a > b) return a - b;
    return '0;
  endfunction

  // advance the frame state by one pixel word; queue the corrected word if any
  task automatic predict_pixel(input tffc_in_t word);
    logic [PIXEL_W-1:0] raw;
    logic [PIXEL_W-1:0] base;
    logic [PIXEL_W-1:0] corr;
    logic               last;
    tffc_out_t          res;
    raw  = word.pixel_value & PIXEL_MASK;
    last = (position_q == POS_LAST);
    if (position_q == '0) begin
      capturing_q   = word.baseline_frame;
      capture_min_q = PIXEL_MAX;
      frame_min_q   = PIXEL_MAX;
      frame_max_q   = '0;
    end
    if (capturing_q) begin
      baseline_mem[position_q] = raw;
      if (raw < capture_min_q) capture_min_q = raw;
      if (last) offset_q = capture_min_q;
    end else begin
      base = clamp_diff(baseline_mem[position_q], offset_q);
      corr = clamp_diff(raw, base);
      if (corr < frame_min_q) frame_min_q = corr;
      if (corr > frame_max_q) frame_max_q = corr;
      res.corrected_pixel = corr;
      res.frame_end       = last;
      res.frame_min       = last ? frame_min_q : '0;
      res.frame_max       = last ? frame_max_q : '0;
      corrected_q.push_back(res);
    end
    position_q = last ? '0 : position_q + 1'b1;
  endtask

  task automatic check_field(input string field, input logic [PIXEL_W-1:0] want,
                             input logic [PIXEL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_word(input tffc_out_t got);
    tffc_out_t want;
    if (corrected_q.size() == 0) begin
      $display("%0t: unexpected word: expected none, actual %h", $time, got);
      fail_count++;
      return;
    end
    want = corrected_q.pop_front();
    check_field("corrected_pixel", want.corrected_pixel, got.corrected_pixel);
    check_field("frame_end", PIXEL_W'(want.frame_end), PIXEL_W'(got.frame_end));
    check_field("frame_min", want.frame_min, got.frame_min);
    check_field("frame_max", want.frame_max, got.frame_max);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAME_PIXELS; i++) baseline_mem[i] = '0;
      offset_q      = '0;
      capture_min_q = PIXEL_MAX;
      frame_min_q   = PIXEL_MAX;
      frame_max_q   = '0;
      position_q    = '0;
      capturing_q   = 1'b0;
      corrected_q.delete();
    end else begin
      if (pix_i.valid && pix_i.ready) predict_pixel(pix_i.payload);
      if (res_i.valid && res_i.ready) compare_word(res_i.payload);
    end
    fail_count_o <= fail_count;
    pending_o    <= corrected_q.size();
  end

endmodule

[tb/tb_thermal_flat_field_correction_core.sv]
`timescale 1ns / 1ps
// Testbench top for thermal_flat_field_correction_core: drives the opening pixels of
// a frame, stalls the result side, and reports the verdict. Depends on tffc_pkg,
// tffc_if and tffc_checker.

module tb_thermal_flat_field_correction_core import tffc_pkg::*; ();

  // cycles the receiver holds off in one go, long enough to fill the core
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // cycles with no word moving on either side before the run is abandoned
  localparam int unsigned QUIET_LIMIT     = 2000;
  // cycles to wait after the last expected word, well past the core's latency
  localparam int unsigned DRAIN_CYCLES    = 16;
  // pixels between re-rolls of the idling pattern
  localparam int unsigned SEGMENT         = 400;
  // pixel words sent in the whole run
  localparam int          RUN_PIXELS      = 1050;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        tx_idle_en   = 1'b0;
  logic        rx_idle_en   = 1'b0;
  logic        hold_off_req = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;

  tffc_in_if  pix_if ();
  tffc_out_if res_if ();

  thermal_flat_field_correction_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_if),
    .res_o  (res_if)
  );

  tffc_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .pix_i        (pix_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pick a pixel for a corrected frame: full-range noise, the extremes, small
  // values and moderate values up to 12000.
  function automatic logic [PIXEL_W-1:0] pick_pixel();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 6) return PIXEL_MAX;
    if (roll < 30) return PIXEL_W'($urandom_range(0, 400));
    if (roll < 55) return PIXEL_W'($urandom);
    return PIXEL_W'($urandom_range(0, 12000));
  endfunction

  // Offer one pixel word and hold it until the core takes it. Signals are read
  // straight after the edge, so they still carry their pre-edge values.
  task automatic push_pixel(input logic [PIXEL_W-1:0] px, input logic flag);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 10);
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid   <= 1'b1;
    pix_if.payload <= tffc_in_t'{pixel_value: px, baseline_frame: flag};
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
  endtask

  // Send pixels first_px up to end_px - 1 of a frame. The flag is set only at
  // the first pixel; elsewhere it is random and must be ignored. hold_at and
  // pause_at mark where the long receiver hold-off and the full drain happen
  // (-1 for none); from calm_from on, neither side idles.
  task automatic send_frame(input logic capture, input int first_px, input int end_px,
                            input int hold_at, input int pause_at, input int calm_from);
    logic flag;
    for (int p = first_px; p < end_px; p++) begin
      if (p >= calm_from) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else if (p % SEGMENT == 0) begin
        tx_idle_en = ($urandom_range(0, 2) != 0);
        rx_idle_en = ($urandom_range(0, 2) != 0);
      end
      if (p == hold_at) begin
        // keep offering every cycle so the core fills and stalls its input
        hold_off_req = 1'b1;
        tx_idle_en   = 1'b0;
      end
      if (p == pause_at) begin
        // drop valid and wait for every outstanding word to come back
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      flag = (p == 0) ? capture : logic'($urandom_range(0, 1));
      push_pixel(pick_pixel(), flag);
    end
  endtask

  initial begin : stimulus
    rst_n          <= 1'b0;
    pix_if.valid   <= 1'b0;
    pix_if.payload <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed start of a corrected frame straight out of reset: the baseline
    // is still zero, so these pass unchanged; the set flags sit mid-frame and
    // must not turn the frame into a capture.
    push_pixel(16'h0000, 1'b0);
    push_pixel(16'hFFFF, 1'b1);
    push_pixel(16'h8000, 1'b1);
    push_pixel(16'h0001, 1'b0);
    push_pixel(16'h7FFF, 1'b1);
    push_pixel(16'hAAAA, 1'b0);
    push_pixel(16'h5555, 1'b1);
    push_pixel(16'h00FF, 1'b0);
    push_pixel(16'hFF00, 1'b1);
    push_pixel(16'hFFFE, 1'b0);

    // carry on with the frame: a long output hold-off, a full drain, and no
    // idling in the last part
    send_frame(1'b0, 10, RUN_PIXELS, 300, 600, 850);

    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: ready by default, with random stall bursts and, on request,
  // one long hold-off counted here.
  initial begin : receiver
    int unsigned burst;
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 11) == 0) begin
        burst = $urandom_range(1, 10);
        res_if.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: give up when no word has moved on either side for too long.
  always @(posedge clk) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
